// ===== hdl/c3kf_pkg.sv =====
// ----------------------------------------------------------------------------
// c3kf_pkg
// Types and constants shared by the 3x3 kernel filter, its port checker
// and its bench.
// ----------------------------------------------------------------------------
`default_nettype none

package c3kf_pkg;

  // Geometry
  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned MAX_HEIGHT    = 1024;

  // Field and register widths
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned ROW_W      = 10;
  localparam int unsigned CFG_W      = 11;
  localparam int unsigned CFG_ADDR_W = 2;

  // Stream payload widths (TDATA widths in whole bytes)
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned OUT_USED_W  = PIX_W + 2 * POS_W;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  // Register reset values
  localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd512;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd512;

  // Register indexes on the write port
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_MODE   = 2'd2
  } cfg_idx_e;

  // Kernel select
  typedef enum logic [2:0] {
    FM_BOX       = 3'd0,
    FM_GAUSS     = 3'd1,
    FM_PREWITT_X = 3'd2,
    FM_PREWITT_Y = 3'd3,
    FM_SOBEL_X   = 3'd4,
    FM_SOBEL_Y   = 3'd5,
    FM_LAPLACE   = 3'd6,
    FM_SHARPEN   = 3'd7
  } filter_mode_e;

  localparam filter_mode_e MODE_RST = FM_GAUSS;

  // Box average: floor(S * 11111 / 100000). Estimate with a reciprocal that
  // never overshoots, then fix up by one with an exact compare.
  localparam int unsigned BOX_NUM   = 11111;
  localparam int unsigned BOX_DEN   = 100000;
  localparam int unsigned BOX_SHIFT = 20;
  localparam int unsigned BOX_RECIP = 116507;  // floor(2^20 * 0.11111)

  // floor(n / 3) = (n * 683) >> 11, exact for n below 768
  localparam int unsigned DIV3_MUL   = 683;
  localparam int unsigned DIV3_SHIFT = 11;

endpackage

`default_nettype wire

// ===== hdl/c3kf_ram.sv =====
// ----------------------------------------------------------------------------
// c3kf_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module c3kf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold the last read word until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/conv3x3_kernel_filter_top.sv =====
// ----------------------------------------------------------------------------
// conv3x3_kernel_filter_top
// Streaming 3x3 convolution filter with selectable kernel.
// ----------------------------------------------------------------------------
// Pixels enter on the s_axis channel in raster order, one per transfer. Each
// pixel that completes a 3x3 window produces one result on the m_axis channel:
// the filtered center value, its row and column, and tlast on the last
// interior pixel of the frame. Border pixels produce nothing.
// Throughput: one pixel per clock, sustained while m_axis_tready stays high. The
// two rows above the current one live in a single 16-bit line memory, read at
// the column of the arriving pixel and written back when that pixel leaves
// stage 1, so consecutive pixels never touch the same entry.
// From the input transfer a pixel passes the memory read into the stage 1
// register, the window sums into stage 2, the kernel arithmetic into stage 3
// and the box correction into the output register that drives m_axis_tvalid.
// Reset clears the position counters, the window and all valid bits and loads
// width 512, height 512 and the Gaussian kernel. The line memory is not
// cleared; every entry is written before it is used as long as the width does not grow inside a frame.
// A stalled receiver fills the output register first, then the internal
// stages one by one; s_axis_tready falls only once every stage holds an item.
// The user must write registers through cfg_we_i only while the pipeline is empty; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3x3_kernel_filter_top #(
  parameter int unsigned MAX_WIDTH = c3kf_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [c3kf_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [c3kf_pkg::CFG_W-1:0]        cfg_wdata_i,
  // pixel input
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [c3kf_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // [7:0] pixel_in
  // filtered output
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] pixel_out, [17:8] center_row, [27:18] center_col, [31:28] zero
  output logic [c3kf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                              m_axis_tlast    // frame_last
);

  import c3kf_pkg::*;

  localparam int unsigned CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CMPW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int unsigned LW   = 2 * PIX_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] width_q, width_d;
  logic [CFG_W-1:0] height_q, height_d;
  filter_mode_e     mode_q, mode_d;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    mode_d   = mode_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_WIDTH:  width_d  = cfg_wdata_i;
        CFG_HEIGHT: height_d = cfg_wdata_i;
        CFG_MODE:   mode_d   = filter_mode_e'(cfg_wdata_i[2:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      mode_q   <= MODE_RST;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      mode_q   <= mode_d;
    end
  end

  // Clamp frame size
  logic [CMPW-1:0] width_ext;
  logic [CW:0]     img_w;
  logic [CFG_W-1:0] img_h;

  assign width_ext = CMPW'(width_q);

  always_comb begin
    if (width_ext < CMPW'(3)) begin
      img_w = (CW + 1)'(3);
    end else if (width_ext > CMPW'(MAX_WIDTH)) begin
      img_w = (CW + 1)'(MAX_WIDTH);
    end else begin
      img_w = (CW + 1)'(width_ext);
    end
    if (height_q < CFG_W'(3)) begin
      img_h = CFG_W'(3);
    end else if (height_q > CFG_W'(MAX_HEIGHT)) begin
      img_h = CFG_W'(MAX_HEIGHT);
    end else begin
      img_h = height_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage handshake
  // --------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic s1_rdy, s2_rdy, s3_rdy, out_rdy;
  logic in_xfer, s1_fire;

  assign out_rdy = !out_v_q || m_axis_tready;
  assign s3_rdy  = !s3_v_q || out_rdy;
  assign s2_rdy  = !s2_v_q || s3_rdy;
  assign s1_rdy  = !s1_v_q || s2_rdy;

  assign s_axis_tready = s1_rdy;
  assign in_xfer       = s_axis_tvalid && s1_rdy;
  assign s1_fire       = s1_v_q && s2_rdy;

  // --------------------------------------------------------------------------
  // Position counters
  // --------------------------------------------------------------------------
  logic [CW-1:0]    col_q, col_d, col_cur;
  logic [ROW_W-1:0] row_q, row_d, row_cur;
  logic             col_wrap;
  logic [ROW_W:0]   row_pre, row_inc;
  logic [CW:0]      col_inc;
  logic             win_full, at_last;

  always_comb begin
    // Wrap first in case the frame size shrank below the current position
    col_wrap = {1'b0, col_q} >= img_w;
    row_pre  = col_wrap ? {1'b0, row_q} + (ROW_W + 1)'(1) : {1'b0, row_q};
    row_cur  = (row_pre >= img_h) ? '0 : row_pre[ROW_W-1:0];
    col_cur  = col_wrap ? '0 : col_q;

    col_inc = {1'b0, col_cur} + (CW + 1)'(1);
    row_inc = {1'b0, row_cur} + (ROW_W + 1)'(1);
    if (col_inc >= img_w) begin
      col_d = '0;
      row_d = (row_inc >= img_h) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_d = col_inc[CW-1:0];
      row_d = row_cur;
    end

    win_full = (row_cur >= ROW_W'(2)) && (col_cur >= CW'(2));
    at_last  = ({1'b0, row_cur} == img_h - CFG_W'(1)) &&
               ({1'b0, col_cur} == img_w - (CW + 1)'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_xfer) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // --------------------------------------------------------------------------
  // Line memory: [15:8] row above, [7:0] two rows above
  // --------------------------------------------------------------------------
  logic [LW-1:0] line_rdata;
  logic [LW-1:0] line_wdata;
  logic [CW-1:0] s1_addr_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [PIX_W-1:0] up1, up2;

  assign up1        = line_rdata[LW-1:PIX_W];
  assign up2        = line_rdata[PIX_W-1:0];
  assign line_wdata = {s1_pix_q, up1};

  c3kf_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_addr_q),
    .wdata_i (line_wdata),
    .re_i    (in_xfer),
    .raddr_i (col_cur),
    .rdata_o (line_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage 1: memory read data arrives, window sums
  // --------------------------------------------------------------------------
  logic             s1_emit_q, s1_last_q;
  logic [POS_W-1:0] s1_crow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_pix_q  <= s_axis_tdata[PIX_W-1:0];
      s1_addr_q <= col_cur;
      s1_crow_q <= POS_W'(row_cur - ROW_W'(1));
      s1_emit_q <= win_full;
      s1_last_q <= at_last;
    end
  end

  // Two left columns: [0..2] left top..bottom, [3..5] middle top..bottom
  logic [PIX_W-1:0] win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_fire) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= up2;
      win_q[4] <= up1;
      win_q[5] <= s1_pix_q;
    end
  end

  logic [PIX_W-1:0] p00, p01, p02, p10, p11, p12, p20, p21, p22;
  logic [9:0]  corn_sum, edge_sum;
  logic [9:0]  lsum, rsum, tsum, bsum;
  logic [9:0]  lwsum, rwsum, twsum, bwsum;
  logic signed [11:0] diff;

  always_comb begin
    p00 = win_q[0];
    p10 = win_q[1];
    p20 = win_q[2];
    p01 = win_q[3];
    p11 = win_q[4];
    p21 = win_q[5];
    p02 = up2;
    p12 = up1;
    p22 = s1_pix_q;

    corn_sum = {2'b0, p00} + {2'b0, p02} + {2'b0, p20} + {2'b0, p22};
    edge_sum = {2'b0, p01} + {2'b0, p10} + {2'b0, p12} + {2'b0, p21};

    lsum  = {2'b0, p00} + {2'b0, p10} + {2'b0, p20};
    rsum  = {2'b0, p02} + {2'b0, p12} + {2'b0, p22};
    tsum  = {2'b0, p00} + {2'b0, p01} + {2'b0, p02};
    bsum  = {2'b0, p20} + {2'b0, p21} + {2'b0, p22};
    lwsum = {2'b0, p00} + {1'b0, p10, 1'b0} + {2'b0, p20};
    rwsum = {2'b0, p02} + {1'b0, p12, 1'b0} + {2'b0, p22};
    twsum = {2'b0, p00} + {1'b0, p01, 1'b0} + {2'b0, p02};
    bwsum = {2'b0, p20} + {1'b0, p21, 1'b0} + {2'b0, p22};

    unique case (mode_q)
      FM_PREWITT_X: diff = $signed({2'b0, rsum}) - $signed({2'b0, lsum});
      FM_PREWITT_Y: diff = $signed({2'b0, bsum}) - $signed({2'b0, tsum});
      FM_SOBEL_X:   diff = $signed({2'b0, rwsum}) - $signed({2'b0, lwsum});
      FM_SOBEL_Y:   diff = $signed({2'b0, bwsum}) - $signed({2'b0, twsum});
      FM_BOX, FM_GAUSS, FM_LAPLACE, FM_SHARPEN: diff = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage 2: kernel arithmetic
  // --------------------------------------------------------------------------
  logic [9:0]         s2_corn_q, s2_edge_q;
  logic [PIX_W-1:0]   s2_ctr_q;
  logic signed [11:0] s2_diff_q;
  logic [POS_W-1:0]   s2_crow_q, s2_ccol_q;
  logic               s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_rdy) begin
      // drop items whose window is not complete yet
      s2_v_q <= s1_v_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      s2_corn_q <= corn_sum;
      s2_edge_q <= edge_sum;
      s2_ctr_q  <= p11;
      s2_diff_q <= diff;
      s2_crow_q <= s1_crow_q;
      s2_ccol_q <= POS_W'(s1_addr_q - CW'(1));
      s2_last_q <= s1_last_q;
    end
  end

  logic               s2_fire;
  logic [10:0]        nb_sum;
  logic [11:0]        all_sum;
  logic [10:0]        dmag;
  logic [11:0]        gauss_sum;
  logic [20:0]        div3_prod;
  logic signed [12:0] lap_v, sharp_v;
  logic [11:0]        lap_mag;
  logic [11:0]        ctr9;
  logic [28:0]        box_prod;
  logic [PIX_W-1:0]   kern_val;

  assign s2_fire = s2_v_q && s3_rdy;

  always_comb begin
    nb_sum    = {1'b0, s2_corn_q} + {1'b0, s2_edge_q};
    all_sum   = {1'b0, nb_sum} + {4'b0, s2_ctr_q};
    dmag      = s2_diff_q[11] ? 11'(-s2_diff_q) : s2_diff_q[10:0];
    gauss_sum = {2'b0, s2_corn_q} + {1'b0, s2_edge_q, 1'b0} + {2'b0, s2_ctr_q, 2'b0};
    div3_prod = {10'b0, dmag} * 21'(DIV3_MUL);
    lap_v     = $signed({2'b0, s2_ctr_q, 3'b0}) - $signed({2'b0, nb_sum});
    lap_mag   = lap_v[12] ? 12'(-lap_v) : lap_v[11:0];
    ctr9      = {1'b0, s2_ctr_q, 3'b0} + {4'b0, s2_ctr_q};
    sharp_v   = $signed({1'b0, ctr9}) - $signed({2'b0, nb_sum});
    box_prod  = {17'b0, all_sum} * 29'(BOX_RECIP);

    unique case (mode_q)
      FM_BOX:       kern_val = box_prod[BOX_SHIFT +: PIX_W];  // estimate, fixed below
      FM_GAUSS:     kern_val = gauss_sum[11:4];
      FM_PREWITT_X,
      FM_PREWITT_Y: kern_val = div3_prod[DIV3_SHIFT +: PIX_W];
      FM_SOBEL_X,
      FM_SOBEL_Y:   kern_val = dmag[9:2];
      FM_LAPLACE:   kern_val = lap_mag[10:3];
      FM_SHARPEN: begin
        priority if (sharp_v[12]) begin
          kern_val = '0;
        end else if (|sharp_v[11:8]) begin
          kern_val = '1;
        end else begin
          kern_val = sharp_v[7:0];
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage 3: box correction, then output register
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] s3_val_q;
  logic [11:0]      s3_sum_q;
  logic [POS_W-1:0] s3_crow_q, s3_ccol_q;
  logic             s3_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      s3_val_q  <= kern_val;
      s3_sum_q  <= all_sum;
      s3_crow_q <= s2_crow_q;
      s3_ccol_q <= s2_ccol_q;
      s3_last_q <= s2_last_q;
    end
  end

  logic             s3_fire;
  logic [PIX_W:0]   box_next;
  logic [25:0]      box_lhs, box_rhs;
  logic [PIX_W-1:0] final_val;

  assign s3_fire = s3_v_q && out_rdy;

  always_comb begin
    box_next = {1'b0, s3_val_q} + (PIX_W + 1)'(1);
    box_lhs  = {14'b0, s3_sum_q} * 26'(BOX_NUM);
    box_rhs  = {17'b0, box_next} * 26'(BOX_DEN);
    if (mode_q == FM_BOX && box_lhs >= box_rhs) begin
      final_val = box_next[PIX_W-1:0];
    end else begin
      final_val = s3_val_q;
    end
  end

  logic [PIX_W-1:0] out_pix_q;
  logic [POS_W-1:0] out_row_q, out_col_q;
  logic             out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_rdy) begin
      out_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_fire) begin
      out_pix_q  <= final_val;
      out_row_q  <= s3_crow_q;
      out_col_q  <= s3_ccol_q;
      out_last_q <= s3_last_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_col_q, out_row_q, out_pix_q};
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== hdl/c3kf_checker.sv =====
// ----------------------------------------------------------------------------
// c3kf_checker
// Port-level checks for the 3x3 kernel filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module c3kf_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [c3kf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // pixel, row, col
  input logic                             m_axis_tlast
);

  import c3kf_pkg::*;

  logic [POS_W-1:0] out_row, out_col;

  assign out_row = m_axis_tdata[PIX_W +: POS_W];
  assign out_col = m_axis_tdata[PIX_W + POS_W +: POS_W];

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("c3kf: stalled result changed");

  // No result lies in the top row or the left column
  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> out_row != '0 && out_col != '0)
    else $error("c3kf: border pixel emitted");

  // With the output register empty every stage can move, so input is taken
  a_elastic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("c3kf: input blocked while output empty");

  // No result straight out of reset
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !m_axis_tvalid)
    else $error("c3kf: result valid right after reset");

  // Padding bits above the column stay zero; checked while both sides are valid
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && s_axis_tvalid |->
      m_axis_tdata[OUT_TDATA_W-1:OUT_USED_W] == '0)
    else $error("c3kf: tdata padding not zero");

endmodule

bind conv3x3_kernel_filter_top c3kf_checker u_c3kf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming 3x3 kernel filter.
// ----------------------------------------------------------------------------
// A short table of pixels and register writes covers every kernel, a full
// frame and the saturating cases. One full-width frame follows. After that,
// random phases change size and kernel between pixel runs. Every pixel
// transfer goes through a bit-exact filter predictor. Each output transfer
// is checked against the oldest predicted result. Both stream sides idle in
// random bursts, except in the last stretch of the run.
// ----------------------------------------------------------------------------
module tb_top;
  import c3kf_pkg::*;

  localparam int unsigned RAND_ITEMS     = 1650;
  localparam int unsigned CALM_ITEMS     = 150;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic             last;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [PIX_W-1:0] pix;
  } filt_res_t;

  typedef enum logic {ROW_REG, ROW_PIX} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    cfg_idx_e         idx;
    logic [CFG_W-1:0] val;       // register value, or the pixel in the low byte
    logic             typed;     // pixel_out below is known by inspection
    logic [PIX_W-1:0] typed_pix;
  } stim_row_t;

  // 4x6 frame: three rows of full white, then one kernel per filtered pixel
  localparam int unsigned STIM_ROWS = 34;
  localparam stim_row_t STIM_TAB [STIM_ROWS] = '{
    '{ROW_REG, CFG_WIDTH,  11'd4,            1'b0, 8'd0},
    '{ROW_REG, CFG_HEIGHT, 11'd6,            1'b0, 8'd0},
    '{ROW_REG, CFG_MODE,   11'(FM_BOX),      1'b0, 8'd0},
    '{ROW_PIX, CFG_WIDTH,  11'd255,          1'b0, 8'd0},
    '{ROW_PIX, CFG_WIDTH,  11'd255,          1'b0, 8'd0},
    '{ROW_PIX, CFG_WIDTH,  11'd255,          1'b0, 8'd0},
    '{ROW_PIX, CFG_WIDTH,  11'd255,          1'b0, 8'd0},
    '{ROW_PIX, CFG_WIDTH,  11'd255,          1'b0, 8'd0},
    '{ROW_PIX, CFG_WIDTH,  11'd255,          1'b0, 8'd0},
    '{ROW_PIX, CFG_WIDTH,  11'd255,          1'b0, 8'd0},
    '{ROW_PIX, CFG_WIDTH,  11'd255,          1'b0, 8'd0},
    '{ROW_PIX, CFG_WIDTH,  11'd255,          1'b0, 8'd0},
    '{ROW_PIX, CFG_WIDTH,  11'd255,          1'b0, 8'd0},
    // box of nine 255s falls just short of 255
    '{ROW_PIX, CFG_WIDTH,  11'd255,          1'b1, 8'd254},
    '{ROW_REG, CFG_MODE,   11'(FM_GAUSS),    1'b0, 8'd0},
    '{ROW_PIX, CFG_WIDTH,  11'd255,          1'b1, 8'd255},
    '{ROW_PIX, CFG_WIDTH,  11'd0,            1'b0, 8'd0},
    '{ROW_PIX, CFG_WIDTH,  11'd0,            1'b0, 8'd0},
    '{ROW_REG, CFG_MODE,   11'(FM_PREWITT_X), 1'b0, 8'd0},
    '{ROW_PIX, CFG_WIDTH,  11'd0,            1'b0, 8'd0},
    '{ROW_REG, CFG_MODE,   11'(FM_PREWITT_Y), 1'b0, 8'd0},
    '{ROW_PIX, CFG_WIDTH,  11'd255,          1'b0, 8'd0},
    '{ROW_PIX, CFG_WIDTH,  11'd255,          1'b0, 8'd0},
    '{ROW_PIX, CFG_WIDTH,  11'd0,            1'b0, 8'd0},
    '{ROW_REG, CFG_MODE,   11'(FM_SOBEL_X),  1'b0, 8'd0},
    '{ROW_PIX, CFG_WIDTH,  11'd255,          1'b0, 8'd0},
    '{ROW_REG, CFG_MODE,   11'(FM_SOBEL_Y),  1'b0, 8'd0},
    '{ROW_PIX, CFG_WIDTH,  11'd0,            1'b0, 8'd0},
    '{ROW_PIX, CFG_WIDTH,  11'd7,            1'b0, 8'd0},
    '{ROW_PIX, CFG_WIDTH,  11'd200,          1'b0, 8'd0},
    '{ROW_REG, CFG_MODE,   11'(FM_LAPLACE),  1'b0, 8'd0},
    '{ROW_PIX, CFG_WIDTH,  11'd0,            1'b0, 8'd0},
    '{ROW_REG, CFG_MODE,   11'(FM_SHARPEN),  1'b0, 8'd0},
    // sharpen on a bright center saturates; last interior pixel of the frame
    '{ROW_PIX, CFG_WIDTH,  11'd255,          1'b1, 8'd255}
  };

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  cfg_idx_e               cfg_addr_i    = CFG_WIDTH;
  logic [CFG_W-1:0]       cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  conv3x3_kernel_filter_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  // Predictor state: registers, line stores, window and position
  logic [CFG_W-1:0] img_width  = WIDTH_RST;
  logic [CFG_W-1:0] img_height = HEIGHT_RST;
  filter_mode_e     img_mode   = MODE_RST;
  logic [PIX_W-1:0] line_up1 [MAX_WIDTH_DEF];
  logic [PIX_W-1:0] line_up2 [MAX_WIDTH_DEF];
  logic [PIX_W-1:0] win_cols [6];
  int unsigned      row_pos  = 0;
  int unsigned      col_pos  = 0;

  filt_res_t   filtered_q [$];
  int unsigned errors       = 0;
  bit          calm         = 1'b0;
  int unsigned gap_odds     = 3;   // one source gap in N pixels, 0 for none
  int unsigned sink_odds    = 8;   // chance of 1 in N that a sink stall starts, 0 for none
  int unsigned sink_hold    = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
      line_up1[i] = '0;
      line_up2[i] = '0;
    end
    for (int i = 0; i < 6; i++) win_cols[i] = '0;
  end

  function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int mag_of(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // Advance the window by one pixel; return 1 when a center is filtered
  function automatic bit predict_filter(input logic [PIX_W-1:0] px, output filt_res_t res);
    int unsigned w, h, col, row;
    int tl, tm, tr, ml, mc, mr, bl, bm, br;
    int corners, edges, nb, v;
    logic [PIX_W-1:0] up1, up2;
    bit hit;
    w = clamp_size(img_width, MAX_WIDTH_DEF);
    h = clamp_size(img_height, MAX_HEIGHT);
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    col = col_pos;
    row = row_pos;
    up1 = line_up1[col];
    up2 = line_up2[col];
    hit = (row >= 2) && (col >= 2);
    res = '0;
    if (hit) begin
      tl = win_cols[0]; ml = win_cols[1]; bl = win_cols[2];
      tm = win_cols[3]; mc = win_cols[4]; bm = win_cols[5];
      tr = up2;         mr = up1;         br = px;
      corners = tl + tr + bl + br;
      edges   = tm + ml + mr + bm;
      nb      = corners + edges;
      case (img_mode)
        FM_BOX:       v = (nb + mc) * 11111 / 100000;
        FM_GAUSS:     v = (corners + 2 * edges + 4 * mc) / 16;
        FM_PREWITT_X: v = mag_of((tr + mr + br) - (tl + ml + bl)) / 3;
        FM_PREWITT_Y: v = mag_of((bl + bm + br) - (tl + tm + tr)) / 3;
        FM_SOBEL_X:   v = mag_of((tr + 2 * mr + br) - (tl + 2 * ml + bl)) / 4;
        FM_SOBEL_Y:   v = mag_of((bl + 2 * bm + br) - (tl + 2 * tm + tr)) / 4;
        FM_LAPLACE:   v = mag_of(8 * mc - nb) / 8;
        default: begin
          v = 9 * mc - nb;
          if (v < 0) v = 0;
          else if (v > 255) v = 255;
        end
      endcase
      res.pix  = v[PIX_W-1:0];
      res.row  = POS_W'(row - 1);
      res.col  = POS_W'(col - 1);
      res.last = (row == h - 1) && (col == w - 1);
    end
    win_cols[0] = win_cols[3];
    win_cols[1] = win_cols[4];
    win_cols[2] = win_cols[5];
    win_cols[3] = up2;
    win_cols[4] = up1;
    win_cols[5] = px;
    line_up2[col] = up1;
    line_up1[col] = px;
    col_pos = col + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = row + 1;
      if (row_pos >= h) row_pos = 0;
    end
    return hit;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly small sizes, now and then one that clamps at either end
  function automatic logic [CFG_W-1:0] pick_size(input int unsigned top);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return CFG_W'($urandom_range(0, 2));
    if (r == 1) return CFG_W'($urandom_range(1024, 2047));
    return CFG_W'($urandom_range(3, top));
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] px, input bit typed,
                            input logic [PIX_W-1:0] typed_pix);
    filt_res_t res;
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_filter(px, res)) begin
      if (typed) res.pix = typed_pix;
      filtered_q.push_back(res);
    end
  endtask

  // Write one register once every result is out and the pipeline has emptied
  task automatic program_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_WIDTH:  img_width  = val;
      CFG_HEIGHT: img_height = val;
      default:    img_mode   = filter_mode_e'(val[2:0]);
    endcase
  endtask

  // Receiver stalls in bursts
  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold     <= sink_hold - 1;
      m_axis_tready <= (sink_hold == 1);
    end else if (!calm && sink_odds != 0 && $urandom_range(1, sink_odds) == 1) begin
      sink_hold     <= $urandom_range(1, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    filt_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected result, actual tdata=%h tlast=%b",
                 $time, m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        e = filtered_q.pop_front();
        if ({m_axis_tlast, m_axis_tdata} !==
            {e.last, {OUT_PAD_W{1'b0}}, e.col, e.row, e.pix}) begin
          $display("%0t: mismatch, expected pix=%0d row=%0d col=%0d last=%b pad=0",
                   $time, e.pix, e.row, e.col, e.last);
          $display("%0t:           actual pix=%0d row=%0d col=%0d last=%b pad=%h",
                   $time, m_axis_tdata[7:0], m_axis_tdata[17:8], m_axis_tdata[27:18],
                   m_axis_tlast, m_axis_tdata[31:28]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned span;
    sent = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < STIM_ROWS; i++) begin
      if (STIM_TAB[i].kind == ROW_REG) begin
        program_reg(STIM_TAB[i].idx, STIM_TAB[i].val);
      end else begin
        send_pixel(STIM_TAB[i].val[7:0], STIM_TAB[i].typed, STIM_TAB[i].typed_pix);
      end
    end

    // Full-width frame from a frame start: writes every line entry three times, so
    // later size changes inside a frame never read an unwritten entry
    program_reg(CFG_WIDTH, 11'h7FF);
    program_reg(CFG_HEIGHT, 11'd3);
    program_reg(CFG_MODE, CFG_W'($urandom_range(0, 7)));
    repeat (3 * MAX_WIDTH_DEF) send_pixel(rand_pixel(), 1'b0, 8'd0);

    while (sent < RAND_ITEMS) begin
      if ($urandom_range(0, 1)) program_reg(CFG_WIDTH, pick_size(12));
      if ($urandom_range(0, 1)) program_reg(CFG_HEIGHT, pick_size(10));
      program_reg(CFG_MODE, CFG_W'($urandom_range(0, 7)));
      gap_odds  = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(2, 8);
      sink_odds = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(3, 10);
      span = $urandom_range(20, 120);
      repeat (span) begin
        send_pixel(rand_pixel(), 1'b0, 8'd0);
        sent++;
        calm = (sent >= RAND_ITEMS - CALM_ITEMS);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
